[sv/lz_token_decompressor_defines.svh]
// Assertion macros for the LZ token decompressor.
// Used by the top level; no other dependencies.
`ifndef LZ_TOKEN_DECOMPRESSOR_DEFINES_SVH
`define LZ_TOKEN_DECOMPRESSOR_DEFINES_SVH
`ifndef SYNTH
`define LZD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define LZD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LZD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LZD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[sv/lzd_pkg.sv]
// Shared types and constants for the LZ token decompressor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzd_pkg;
	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int CHUNK = 16;
	localparam int LEN_W = 10;
	localparam int DIST_W = 13;

	localparam logic [7:0] TOK_SHORT = 8'h80;
	localparam logic [7:0] TOK_MID   = 8'hC0;
	localparam logic [7:0] TOK_LONG  = 8'hE0;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DISTANCE = 2'd1;
	localparam logic [1:0] ST_OVERRUN  = 2'd2;
	localparam logic [1:0] ST_TRUNC    = 2'd3;

	typedef enum logic [1:0] {
		PH_CONTROL, PH_LITERAL, PH_EXTRA1, PH_EXTRA2
	} phase_t;

	typedef enum logic [1:0] {
		CS_IDLE, CS_READ, CS_WRITE, CS_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic take;
		logic rd;
		logic wr;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_copy;
		logic chunk_last;
		logic run_over;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

[sv/lzd_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[sv/lzd_ctrl.sv]
// Sequencer for the LZ token decompressor: accept, history read/write, chunk emit.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzd_ctrl import lzd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);
	ctl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid && stat.out_free && stat.start_copy) state_n = CS_READ;
			end
			CS_READ:  state_n = CS_WRITE;
			CS_WRITE: state_n = stat.chunk_last ? CS_EMIT : CS_READ;
			CS_EMIT: begin
				if (stat.out_free) state_n = stat.run_over ? CS_IDLE : CS_READ;
			end
			default:  state_n = CS_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			CS_IDLE: begin
				in_ready = stat.out_free;
				cmd.take = in_valid && stat.out_free;
			end
			CS_READ:  cmd.rd = 1'b1;
			CS_WRITE: cmd.wr = 1'b1;
			CS_EMIT:  cmd.emit = stat.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

[sv/lzd_datapath.sv]
// Token decode, stream state, history window and output register.
// Depends on lzd_pkg and lzd_ram.
`timescale 1ns / 1ps
`default_nettype none
module lzd_datapath import lzd_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctrl_cmd_t   cmd,
	output dp_stat_t         stat,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	input  wire logic        cfg_valid,
	input  wire logic [31:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      chunk_low,
	output logic [63:0]      chunk_high,
	output logic [4:0]       byte_count,
	output logic             run_end,
	output logic             stream_done,
	output logic [1:0]       status
);
	localparam int AW = $clog2(WINDOW_SIZE);

	phase_t              phase_q, ph_n;
	logic [7:0]          token_q, tok_n, first_q, fe_n;
	logic [6:0]          lit_q, lit_n;
	logic [31:0]         produced_q, limit_q;
	logic [1:0]          fault_q, fault_n;
	logic [AW-1:0]       wp_q, wp_inc, raddr;
	logic [LEN_W-1:0]    rem_q, mlen;
	logic [DIST_W-1:0]   dist_q, mdist;
	logic                fin_q;
	logic [CHUNK-1:0][7:0] lane_q;
	logic [4:0]          cnt_q;
	logic                is_match, lit_op, lit_ok, start_copy;
	logic [7:0]          rdata;
	logic                we;
	logic [7:0]          wdata;
	logic [AW:0]         wpx, distx;
	logic                out_free, single_res, last_res;

	assign out_free = !out_valid || out_ready;

	// decode of the presented byte against the current stream state
	always_comb begin
		ph_n = phase_q;
		tok_n = token_q;
		fe_n = first_q;
		lit_n = lit_q;
		fault_n = fault_q;
		is_match = 1'b0;
		lit_op = 1'b0;
		mlen = '0;
		mdist = '0;
		if (fault_q == ST_OK) begin
			case (phase_q)
				PH_CONTROL: begin
					tok_n = data_byte;
					if (data_byte < TOK_SHORT) begin
						lit_n = data_byte[6:0];
						ph_n = (data_byte != 8'd0) ? PH_LITERAL : PH_CONTROL;
					end else if (data_byte < TOK_MID) begin
						is_match = 1'b1;
						mlen = LEN_W'(data_byte[7:4]) - LEN_W'(7);
						mdist = DIST_W'(data_byte[3:0]) + DIST_W'(1);
					end else begin
						ph_n = PH_EXTRA1;
					end
				end
				PH_LITERAL: begin
					lit_op = 1'b1;
					lit_n = lit_q - 7'(lit_q != 7'd0);
					if (lit_n == 7'd0) ph_n = PH_CONTROL;
				end
				PH_EXTRA1: begin
					if (token_q < TOK_LONG) begin
						ph_n = PH_CONTROL;
						is_match = 1'b1;
						mlen = LEN_W'(token_q[4:0]) + LEN_W'(2);
						mdist = DIST_W'(data_byte) + DIST_W'(1);
					end else begin
						fe_n = data_byte;
						ph_n = PH_EXTRA2;
					end
				end
				default: begin
					ph_n = PH_CONTROL;
					is_match = 1'b1;
					mlen = LEN_W'({token_q[4:0], first_q[7:4]}) + LEN_W'(3);
					mdist = DIST_W'({first_q[3:0], data_byte}) + DIST_W'(1);
				end
			endcase
			if (lit_op && produced_q >= limit_q) fault_n = ST_OVERRUN;
			if (is_match) begin
				if (32'(mdist) > produced_q) begin
					fault_n = ST_DISTANCE;
				end else if ({1'b0, produced_q} + 33'(mlen) > {1'b0, limit_q}) begin
					fault_n = ST_OVERRUN;
				end
			end
			if (final_byte && fault_n == ST_OK && ph_n != PH_CONTROL) fault_n = ST_TRUNC;
		end
	end

	assign lit_ok = lit_op && (fault_n != ST_OVERRUN);
	assign start_copy = is_match && (fault_n == ST_OK);
	assign single_res = cmd.take && !start_copy;
	assign last_res = cmd.emit && (rem_q == '0);

	assign stat.start_copy = start_copy;
	assign stat.chunk_last = (cnt_q == 5'(CHUNK - 1)) || (rem_q == LEN_W'(1));
	assign stat.run_over = (rem_q == '0);
	assign stat.out_free = out_free;

	// history addressing, wraps at the window size
	assign wp_inc = (wp_q == AW'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
	assign wpx = {1'b0, wp_q};
	assign distx = (AW + 1)'(dist_q);
	always_comb begin
		if (wpx >= distx) raddr = AW'(wpx - distx);
		else raddr = AW'(wpx + (AW + 1)'(WINDOW_SIZE) - distx);
	end
	assign we = (cmd.take && lit_ok) || cmd.wr;
	assign wdata = cmd.wr ? rdata : data_byte;

	lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CONTROL;
			token_q <= '0;
			first_q <= '0;
			lit_q <= '0;
			produced_q <= '0;
			fault_q <= ST_OK;
			wp_q <= '0;
			limit_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) limit_q <= cfg_data;
			if (single_res || cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.take) begin
				fin_q <= final_byte;
				if (single_res && final_byte) begin
					// stream ends with this single result
					phase_q <= PH_CONTROL;
					token_q <= '0;
					first_q <= '0;
					lit_q <= '0;
					produced_q <= '0;
					fault_q <= ST_OK;
					wp_q <= '0;
				end else begin
					phase_q <= ph_n;
					token_q <= tok_n;
					first_q <= fe_n;
					lit_q <= lit_n;
					fault_q <= fault_n;
					if (lit_ok) begin
						produced_q <= produced_q + 32'd1;
						wp_q <= wp_inc;
					end
				end
				if (start_copy) begin
					rem_q <= mlen;
					cnt_q <= '0;
				end
			end
			if (cmd.wr) begin
				produced_q <= produced_q + 32'd1;
				wp_q <= wp_inc;
				rem_q <= rem_q - LEN_W'(1);
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.emit) begin
				cnt_q <= '0;
				if (last_res && fin_q) begin
					phase_q <= PH_CONTROL;
					token_q <= '0;
					first_q <= '0;
					lit_q <= '0;
					produced_q <= '0;
					fault_q <= ST_OK;
					wp_q <= '0;
				end
			end
		end
	end

	// chunk lanes and output payload
	always_ff @(posedge clk) begin
		if (cmd.take && start_copy) begin
			dist_q <= mdist;
			lane_q <= '0;
		end
		if (cmd.wr) lane_q[cnt_q[3:0]] <= rdata;
		if (single_res) begin
			chunk_low <= {56'd0, lit_ok ? data_byte : 8'd0};
			chunk_high <= '0;
			byte_count <= lit_ok ? 5'd1 : 5'd0;
			run_end <= 1'b1;
			stream_done <= final_byte;
			status <= fault_n;
		end
		if (cmd.emit) begin
			chunk_low <= lane_q[7:0];
			chunk_high <= lane_q[15:8];
			byte_count <= cnt_q;
			run_end <= last_res;
			stream_done <= last_res && fin_q;
			status <= fault_q;
			lane_q <= '0;
		end
	end
endmodule
`default_nettype wire

[sv/lz_token_decompressor.sv]
// Top level of the LZ token decompressor: sequencer plus datapath.
// Depends on lzd_pkg, lzd_ctrl, lzd_datapath, lzd_ram and the defines header.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one compressed byte per
//    transaction, final_byte marking the last byte of a stream.
//  - Output channel (out_valid/out_ready) carries chunks of up to 16 decoded
//    bytes; byte_count 0 means a status-only result. run_end marks the last
//    result caused by an input byte, stream_done the end of a stream.
//  - cfg_valid/cfg_ready writes output_limit; write it only while idle.
// Throughput and sequencing:
//  - A literal, control or extra byte is taken in CS_IDLE and its single result
//    is registered in the next cycle: one byte per cycle while out_ready is high.
//  - A match copies each byte by a history RAM read, then a write, so
//    overlapping copies see every fresh byte, and emits each chunk of 16 once
//    the result register is free; input stalls until the last chunk is loaded.
// Reset clears the stream state, output_limit and out_valid, not the output
// payload; the history RAM is not cleared, a distance is checked before any read.
// A stalled receiver holds the result register and in turn stalls input.
`timescale 1ns / 1ps
`default_nettype none
`include "lz_token_decompressor_defines.svh"
module lz_token_decompressor import lzd_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      chunk_low,
	output logic [63:0]      chunk_high,
	output logic [4:0]       byte_count,
	output logic             run_end,
	output logic             stream_done,
	output logic [1:0]       status
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// limit register always takes the write
	assign cfg_ready = 1'b1;

	lzd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lzd_datapath #(.WINDOW_SIZE(WINDOW_SIZE)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chunk_low   (chunk_low),
		.chunk_high  (chunk_high),
		.byte_count  (byte_count),
		.run_end     (run_end),
		.stream_done (stream_done),
		.status      (status)
	);

	// input is only taken when the result register can be loaded
	`LZD_ASSERT_IMP(a_ready_room, clk, arst_n, in_ready, !out_valid || out_ready, "in_ready without room")
	// a history read is always followed by its write
	`LZD_ASSERT_NXT(a_rd_wr, clk, arst_n, cmd.rd, cmd.wr, "read not followed by write")
	// status-only results are single results
	`LZD_ASSERT_IMP(a_status_last, clk, arst_n, out_valid && byte_count == 5'd0, run_end, "status result not last")
	`LZD_ASSERT_IMP(a_done_end, clk, arst_n, out_valid && stream_done, run_end, "stream_done without run_end")
endmodule
`default_nettype wire
